[hdl/lfbd_pkg.sv]
// Package for the length framed byte deframer.
// Holds shared constants, event and phase codes, and the command and config types.
// No dependencies.
`default_nettype none

package lfbd_pkg;

    localparam int NAME_BYTES_DEF = 8;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HANDSHAKE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NAME      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_LEN  = 3'd5;

    localparam logic [7:0] HEADER_RST    = 8'd1;
    localparam logic [7:0] FOOTER_RST    = 8'd4;
    localparam logic [7:0] HANDSHAKE_RST = 8'd5;
    localparam logic [7:0] HEARTBEAT_RST = 8'd6;

    typedef enum logic [2:0] {
        EV_START     = 3'd0,
        EV_LENGTH    = 3'd1,
        EV_PAYLOAD   = 3'd2,
        EV_GOOD      = 3'd3,
        EV_BADFOOT   = 3'd4,
        EV_HEARTBEAT = 3'd5,
        EV_INVALID   = 3'd6,
        EV_REPLY     = 3'd7
    } t_event;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_FOOTER  = 2'd3
    } t_phase;

    typedef enum logic {
        BK_IDLE  = 1'b0,
        BK_REPLY = 1'b1
    } t_back_st;

    typedef struct packed {
        logic [7:0] header_code;
        logic [7:0] footer_code;
        logic [7:0] handshake_code;
        logic [7:0] heartbeat_code;
        logic [3:0] name_len;
    } t_cfg;

    typedef struct packed {
        logic       is_reply;
        t_event     ev;
        logic [7:0] data;
        logic [7:0] pos;
        logic [7:0] flen;
    } t_cmd;

endpackage

`default_nettype wire

[hdl/lfbd_front.sv]
// Front end: phase tracking and classification of each received word.
// Produces one command per accepted word. Depends on lfbd_pkg.
`default_nettype none

module lfbd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lfbd_pkg::t_cfg i_cfg,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_rx_byte,
    output lfbd_pkg::t_cmd     o_cmd
);

    lfbd_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_length, n_length;
    logic [7:0]       r_count, n_count;
    logic [7:0]       count_inc;

    assign count_inc = r_count + 8'd1;

    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            case (r_phase)
                lfbd_pkg::PH_HEADER: begin
                    if (i_rx_byte == i_cfg.header_code) begin
                        n_phase = lfbd_pkg::PH_LENGTH;
                    end
                end
                lfbd_pkg::PH_LENGTH: begin
                    n_phase = (i_rx_byte == 8'd0) ? lfbd_pkg::PH_FOOTER
                                                  : lfbd_pkg::PH_PAYLOAD;
                end
                lfbd_pkg::PH_PAYLOAD: begin
                    if (count_inc >= r_length) begin
                        n_phase = lfbd_pkg::PH_FOOTER;
                    end
                end
                lfbd_pkg::PH_FOOTER: begin
                    n_phase = lfbd_pkg::PH_HEADER;
                end
                default: begin
                    n_phase = lfbd_pkg::PH_HEADER;
                end
            endcase
        end
    end

    always_comb begin
        n_length       = r_length;
        n_count        = r_count;
        o_cmd.is_reply = 1'b0;
        o_cmd.ev       = lfbd_pkg::EV_INVALID;
        o_cmd.data     = i_rx_byte;
        o_cmd.pos      = 8'd0;
        o_cmd.flen     = 8'd0;
        case (r_phase)
            lfbd_pkg::PH_HEADER: begin
                if (i_rx_byte == i_cfg.header_code) begin
                    o_cmd.ev = lfbd_pkg::EV_START;
                end else if (i_rx_byte == i_cfg.handshake_code) begin
                    o_cmd.is_reply = 1'b1;
                    o_cmd.ev       = lfbd_pkg::EV_REPLY;
                end else if (i_rx_byte == i_cfg.heartbeat_code) begin
                    o_cmd.ev = lfbd_pkg::EV_HEARTBEAT;
                end
            end
            lfbd_pkg::PH_LENGTH: begin
                o_cmd.ev   = lfbd_pkg::EV_LENGTH;
                o_cmd.flen = i_rx_byte;
                if (i_accept) begin
                    n_length = i_rx_byte;
                    n_count  = 8'd0;
                end
            end
            lfbd_pkg::PH_PAYLOAD: begin
                o_cmd.ev   = lfbd_pkg::EV_PAYLOAD;
                o_cmd.pos  = r_count;
                o_cmd.flen = r_length;
                if (i_accept) begin
                    n_count = count_inc;
                end
            end
            lfbd_pkg::PH_FOOTER: begin
                o_cmd.ev   = (i_rx_byte == i_cfg.footer_code) ? lfbd_pkg::EV_GOOD
                                                              : lfbd_pkg::EV_BADFOOT;
                o_cmd.flen = r_length;
            end
            default: begin
                o_cmd.ev = lfbd_pkg::EV_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= lfbd_pkg::PH_HEADER;
            r_length <= 8'd0;
            r_count  <= 8'd0;
        end else begin
            r_phase  <= n_phase;
            r_length <= n_length;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

[hdl/lfbd_fifo.sv]
// Short command queue between front and back end.
// Depth from lfbd_pkg::QUEUE_DEPTH (power of two). Depends on lfbd_pkg.
`default_nettype none

module lfbd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lfbd_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output lfbd_pkg::t_cmd      o_cmd,
    output logic                o_empty,
    output logic                o_full
);

    localparam int PW = $clog2(lfbd_pkg::QUEUE_DEPTH);
    localparam int CW = PW + 1;

    lfbd_pkg::t_cmd r_mem [lfbd_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_empty = (r_cnt == CW'(0));
    assign o_full  = (r_cnt == CW'(lfbd_pkg::QUEUE_DEPTH));
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/lfbd_back.sv]
// Back end: executes queued commands and drives the registered output word.
// Expands a handshake command into the reply frame. Depends on lfbd_pkg.
`default_nettype none

module lfbd_back #(
    parameter int NAME_BYTES = lfbd_pkg::NAME_BYTES_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire lfbd_pkg::t_cfg          i_cfg,
    input  wire logic [NAME_BYTES*8-1:0] i_name,
    input  wire lfbd_pkg::t_cmd          i_cmd,
    input  wire logic                    i_empty,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [2:0]                   o_event_res,
    output logic [7:0]                   o_data,
    output logic [7:0]                   o_position,
    output logic [7:0]                   o_frame_length,
    output logic                         o_last
);

    localparam int SW = $clog2(NAME_BYTES + 3);
    localparam int IW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;

    lfbd_pkg::t_back_st r_state, n_state;
    logic [SW-1:0]      r_step, n_step;
    logic               r_valid, n_valid;
    lfbd_pkg::t_event   r_ev, n_ev;
    logic [7:0]         r_data, n_data, r_pos, n_pos, r_flen, n_flen;
    logic               r_last, n_last;

    logic               out_free;
    logic [3:0]         len_sat;
    logic               step_end;
    logic [SW-1:0]      name_off;
    logic [IW-1:0]      name_idx;
    logic [7:0]         name_byte;

    assign out_free  = !r_valid || !i_out_stall;
    assign len_sat   = (i_cfg.name_len > 4'(NAME_BYTES)) ? 4'(NAME_BYTES) : i_cfg.name_len;
    assign step_end  = (r_step == (SW'(len_sat) + SW'(2)));
    assign name_off  = r_step - SW'(2);
    assign name_idx  = name_off[IW-1:0];
    assign name_byte = i_name[name_idx*8 +: 8];

    always_comb begin
        n_state = r_state;
        case (r_state)
            lfbd_pkg::BK_IDLE: begin
                if (out_free && !i_empty && i_cmd.is_reply) begin
                    n_state = lfbd_pkg::BK_REPLY;
                end
            end
            lfbd_pkg::BK_REPLY: begin
                if (out_free && step_end) begin
                    n_state = lfbd_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = lfbd_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        n_step  = r_step;
        n_valid = r_valid;
        n_ev    = r_ev;
        n_data  = r_data;
        n_pos   = r_pos;
        n_flen  = r_flen;
        n_last  = r_last;
        case (r_state)
            lfbd_pkg::BK_IDLE: begin
                if (out_free) begin
                    o_pop   = !i_empty;
                    n_valid = !i_empty;
                    if (i_cmd.is_reply) begin
                        n_ev   = lfbd_pkg::EV_REPLY;
                        n_data = i_cfg.header_code;
                        n_pos  = 8'd0;
                        n_flen = 8'(len_sat);
                        n_last = 1'b0;
                        n_step = SW'(1);
                    end else begin
                        n_ev   = i_cmd.ev;
                        n_data = i_cmd.data;
                        n_pos  = i_cmd.pos;
                        n_flen = i_cmd.flen;
                        n_last = 1'b1;
                    end
                end
            end
            lfbd_pkg::BK_REPLY: begin
                if (out_free) begin
                    n_valid = 1'b1;
                    n_ev    = lfbd_pkg::EV_REPLY;
                    n_pos   = 8'd0;
                    n_flen  = 8'(len_sat);
                    n_last  = step_end;
                    n_step  = r_step + SW'(1);
                    if (step_end) begin
                        n_data = i_cfg.footer_code;
                    end else if (r_step == SW'(1)) begin
                        n_data = 8'(len_sat);
                    end else begin
                        n_data = name_byte;
                    end
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfbd_pkg::BK_IDLE;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev   <= n_ev;
        r_data <= n_data;
        r_pos  <= n_pos;
        r_flen <= n_flen;
        r_last <= n_last;
    end

    assign o_out_valid    = r_valid;
    assign o_event_res    = r_ev;
    assign o_data         = r_data;
    assign o_position     = r_pos;
    assign o_frame_length = r_flen;
    assign o_last         = r_last;

endmodule

`default_nettype wire

[hdl/length_framed_byte_deframer.sv]
// Length framed byte deframer: one received word per cycle while the command queue is not full.
// A result passes through the command queue and the registered output word, held while stalled.
// A handshake occupies the output for a reply frame of header, name length, name bytes and
// footer, while a 4 entry command queue keeps accepting words until full.
// Reset (synchronous, active low) clears phase, queue and output valid, and loads default codes.
// Depends on lfbd_pkg, lfbd_front, lfbd_fifo, lfbd_back.
`default_nettype none

module length_framed_byte_deframer #(
    parameter int NAME_BYTES = lfbd_pkg::NAME_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lfbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lfbd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [7:0]                      i_rx_byte,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [2:0]                           o_event_res,
    output logic [7:0]                           o_data,
    output logic [7:0]                           o_position,
    output logic [7:0]                           o_frame_length,
    output logic                                 o_last
);

    lfbd_pkg::t_cfg          r_cfg;
    logic [NAME_BYTES*8-1:0] r_name;
    lfbd_pkg::t_cmd          front_cmd, queue_cmd;
    logic                    accept, pop, empty, full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_code    <= lfbd_pkg::HEADER_RST;
            r_cfg.footer_code    <= lfbd_pkg::FOOTER_RST;
            r_cfg.handshake_code <= lfbd_pkg::HANDSHAKE_RST;
            r_cfg.heartbeat_code <= lfbd_pkg::HEARTBEAT_RST;
            r_cfg.name_len       <= 4'd0;
            r_name               <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lfbd_pkg::REG_HEADER:    r_cfg.header_code    <= i_cfg_wdata[7:0];
                lfbd_pkg::REG_FOOTER:    r_cfg.footer_code    <= i_cfg_wdata[7:0];
                lfbd_pkg::REG_HANDSHAKE: r_cfg.handshake_code <= i_cfg_wdata[7:0];
                lfbd_pkg::REG_HEARTBEAT: r_cfg.heartbeat_code <= i_cfg_wdata[7:0];
                lfbd_pkg::REG_NAME:      r_name <= i_cfg_wdata[NAME_BYTES*8-1:0];
                lfbd_pkg::REG_NAME_LEN:  r_cfg.name_len <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    lfbd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_cmd     (front_cmd)
    );

    lfbd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_empty (empty),
        .o_full  (full)
    );

    lfbd_back #(
        .NAME_BYTES (NAME_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_name         (r_name),
        .i_cmd          (queue_cmd),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_res    (o_event_res),
        .o_data         (o_data),
        .o_position     (o_position),
        .o_frame_length (o_frame_length),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

[hdl/lfbd_checker.sv]
// Port level checks for the length framed byte deframer, bound to the top level.
// Depends on lfbd_pkg and length_framed_byte_deframer.
`default_nettype none

module lfbd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [2:0] o_event_res,
    input wire logic [7:0] o_data,
    input wire logic [7:0] o_position,
    input wire logic       o_last
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_data) && $stable(o_event_res) && $stable(o_last))
        else $error("stalled output word changed");

    a_reply_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last &&
            (o_event_res == lfbd_pkg::EV_REPLY) |=>
            o_out_valid && (o_event_res == lfbd_pkg::EV_REPLY))
        else $error("reply frame broken");

    a_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res != lfbd_pkg::EV_PAYLOAD) |-> (o_position == 8'd0))
        else $error("position set outside payload");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res != lfbd_pkg::EV_REPLY) |-> o_last)
        else $error("single result not marked last");

endmodule

bind length_framed_byte_deframer lfbd_checker u_lfbd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_event_res    (o_event_res),
    .o_data         (o_data),
    .o_position     (o_position),
    .o_last         (o_last)
);

`default_nettype wire

[bench/length_framed_byte_deframer_tb.sv]
`timescale 1ns / 1ps
// Testbench for length_framed_byte_deframer: directed and random byte streams checked
// word by word against a behavioural deframer kept in the bench.
// Depends on lfbd_pkg and the RTL of the deframer only.

module length_framed_byte_deframer_tb;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 8;
    localparam int IDLE_PERCENT    = 12;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int RANDOM_PHASES   = 6;
    localparam int WORDS_PER_PHASE = 16;

    typedef struct packed {
        lfbd_pkg::t_event ev;
        logic [7:0]       data;
        logic [7:0]       pos;
        logic [7:0]       flen;
        logic             last;
    } t_result;

    logic                            i_clk;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [lfbd_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [lfbd_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_stall;
    logic [7:0]                      i_rx_byte   = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [2:0]                      o_event_res;
    logic [7:0]                      o_data;
    logic [7:0]                      o_position;
    logic [7:0]                      o_frame_length;
    logic                            o_last;

    // bench copy of the registers and of the deframer state
    logic [7:0]       hdr_code     = lfbd_pkg::HEADER_RST;
    logic [7:0]       ftr_code     = lfbd_pkg::FOOTER_RST;
    logic [7:0]       hs_code      = lfbd_pkg::HANDSHAKE_RST;
    logic [7:0]       hb_code      = lfbd_pkg::HEARTBEAT_RST;
    logic [63:0]      name_word    = '0;
    logic [3:0]       name_len_cfg = '0;
    lfbd_pkg::t_phase rx_phase     = lfbd_pkg::PH_HEADER;
    logic [7:0]       frame_len    = '0;
    logic [7:0]       byte_idx     = '0;

    t_result expected_results[$];
    int      n_errors      = 0;
    int      words_sent    = 0;
    int      quiet_cycles  = 0;
    bit      src_idle_en   = 1'b1;
    bit      dst_idle_en   = 1'b1;
    bit      hold_off_req  = 1'b0;

    length_framed_byte_deframer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_res    (o_event_res),
        .o_data         (o_data),
        .o_position     (o_position),
        .o_frame_length (o_frame_length),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void queue_result(input lfbd_pkg::t_event ev, input logic [7:0] data,
                                         input logic [7:0] pos, input logic [7:0] flen,
                                         input logic last);
        t_result r;
        r.ev   = ev;
        r.data = data;
        r.pos  = pos;
        r.flen = flen;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        logic [7:0] nlen;
        nlen = (name_len_cfg > lfbd_pkg::NAME_BYTES_DEF) ? 8'(lfbd_pkg::NAME_BYTES_DEF)
                                                         : 8'(name_len_cfg);
        case (rx_phase)
            lfbd_pkg::PH_HEADER: begin
                if (b == hdr_code) begin
                    queue_result(lfbd_pkg::EV_START, b, 8'd0, 8'd0, 1'b1);
                    rx_phase = lfbd_pkg::PH_LENGTH;
                end else if (b == hs_code) begin
                    queue_result(lfbd_pkg::EV_REPLY, hdr_code, 8'd0, nlen, 1'b0);
                    queue_result(lfbd_pkg::EV_REPLY, nlen, 8'd0, nlen, 1'b0);
                    for (int i = 0; i < nlen; i++)
                        queue_result(lfbd_pkg::EV_REPLY, name_word[8*i +: 8], 8'd0, nlen,
                                     1'b0);
                    queue_result(lfbd_pkg::EV_REPLY, ftr_code, 8'd0, nlen, 1'b1);
                end else if (b == hb_code) begin
                    queue_result(lfbd_pkg::EV_HEARTBEAT, b, 8'd0, 8'd0, 1'b1);
                end else begin
                    queue_result(lfbd_pkg::EV_INVALID, b, 8'd0, 8'd0, 1'b1);
                end
            end
            lfbd_pkg::PH_LENGTH: begin
                frame_len = b;
                byte_idx  = 8'd0;
                rx_phase  = (b == 8'd0) ? lfbd_pkg::PH_FOOTER : lfbd_pkg::PH_PAYLOAD;
                queue_result(lfbd_pkg::EV_LENGTH, b, 8'd0, b, 1'b1);
            end
            lfbd_pkg::PH_PAYLOAD: begin
                queue_result(lfbd_pkg::EV_PAYLOAD, b, byte_idx, frame_len, 1'b1);
                byte_idx = byte_idx + 8'd1;
                if (byte_idx >= frame_len)
                    rx_phase = lfbd_pkg::PH_FOOTER;
            end
            default: begin
                queue_result((b == ftr_code) ? lfbd_pkg::EV_GOOD : lfbd_pkg::EV_BADFOOT,
                             b, 8'd0, frame_len, 1'b1);
                rx_phase = lfbd_pkg::PH_HEADER;
            end
        endcase
    endfunction

    function automatic void store_register(input logic [lfbd_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [lfbd_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            lfbd_pkg::REG_HEADER:    hdr_code     = value[7:0];
            lfbd_pkg::REG_FOOTER:    ftr_code     = value[7:0];
            lfbd_pkg::REG_HANDSHAKE: hs_code      = value[7:0];
            lfbd_pkg::REG_HEARTBEAT: hb_code      = value[7:0];
            lfbd_pkg::REG_NAME:      name_word    = value;
            lfbd_pkg::REG_NAME_LEN:  name_len_cfg = value[3:0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            n_errors++;
        end
    endfunction

    task automatic send_word(input logic [7:0] b);
        if (src_idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        deframe_byte(b);
        words_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // upper bits of the narrow registers carry noise and must be dropped
    task automatic apply_config(input logic [7:0] hdr, input logic [7:0] ftr,
                                input logic [7:0] hs, input logic [7:0] hb,
                                input logic [63:0] name, input logic [3:0] nlen);
        logic [lfbd_pkg::CFG_DATA_W-1:0] vals [0:7];
        for (int k = 0; k < 8; k++)
            vals[k] = {$urandom, $urandom};
        vals[lfbd_pkg::REG_HEADER][7:0]    = hdr;
        vals[lfbd_pkg::REG_FOOTER][7:0]    = ftr;
        vals[lfbd_pkg::REG_HANDSHAKE][7:0] = hs;
        vals[lfbd_pkg::REG_HEARTBEAT][7:0] = hb;
        vals[lfbd_pkg::REG_NAME]           = name;
        vals[lfbd_pkg::REG_NAME_LEN][3:0]  = nlen;
        wait_idle();
        for (int k = 0; k < 8; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= lfbd_pkg::CFG_IDX_W'(k);
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            store_register(lfbd_pkg::CFG_IDX_W'(k), vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_frame(input int unsigned len, input logic [7:0] footer);
        send_word(hdr_code);
        send_word(8'(len));
        repeat (len) send_word(8'($urandom));
        send_word(footer);
    endtask

    task automatic send_random_sequence();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
            send_frame(len, ($urandom_range(0, 9) == 0) ? 8'($urandom) : ftr_code);
        end else if (pick < 70) begin
            send_word(hs_code);
        end else if (pick < 80) begin
            send_word(hb_code);
        end else if (pick < 90) begin
            send_word(8'($urandom));
        end else begin
            // truncated frame: the following words finish it
            len = $urandom_range(2, 8);
            send_word(hdr_code);
            send_word(8'(len));
            repeat ($urandom_range(0, len - 1)) send_word(8'($urandom));
        end
    endtask

    task automatic test_reset_defaults();
        send_word(lfbd_pkg::HEARTBEAT_RST);
        send_word(8'h00);
        send_word(8'hFF);
        send_word(lfbd_pkg::HANDSHAKE_RST);
        send_word(lfbd_pkg::HEADER_RST);
        send_word(8'd3);
        send_word(8'hFF);
        send_word(8'h00);
        send_word(8'hA5);
        send_word(lfbd_pkg::FOOTER_RST);
        send_frame(0, lfbd_pkg::FOOTER_RST);
        // bad footer equal to the header code: reported as a bad footer, not taken as a header
        send_word(lfbd_pkg::HEADER_RST);
        send_word(8'd1);
        send_word(8'h5A);
        send_word(lfbd_pkg::HEADER_RST);
        send_word(lfbd_pkg::HEARTBEAT_RST);
    endtask

    task automatic test_code_overlap();
        apply_config(8'h00, 8'hFF, 8'h00, 8'h00, {$urandom, $urandom}, 4'd8);
        send_frame(0, 8'hFF);
        apply_config(8'hFF, 8'h00, 8'h07, 8'h07, '1, 4'd15);
        send_word(8'h07);
        send_frame(0, 8'h00);
    endtask

    task automatic test_random_traffic();
        logic [7:0] hdr;
        logic [7:0] hs;
        logic [7:0] hb;
        int         stop_at;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            hdr = 8'($urandom);
            hs  = ($urandom_range(0, 7) == 0) ? hdr : 8'($urandom);
            hb  = ($urandom_range(0, 7) == 0) ? hs : 8'($urandom);
            apply_config(hdr, 8'($urandom), hs, hb, {$urandom, $urandom},
                         4'($urandom_range(0, 15)));
            src_idle_en = (p != 2);
            dst_idle_en = (p != 2);
            stop_at = words_sent + WORDS_PER_PHASE;
            while (words_sent < stop_at)
                send_random_sequence();
        end
        src_idle_en = 1'b1;
        dst_idle_en = 1'b1;
    endtask

    task automatic test_output_holdoff();
        apply_config(lfbd_pkg::HEADER_RST, lfbd_pkg::FOOTER_RST, lfbd_pkg::HANDSHAKE_RST,
                     lfbd_pkg::HEARTBEAT_RST, {$urandom, $urandom}, 4'd8);
        hold_off_req = 1'b1;
        repeat (6) send_word(lfbd_pkg::HANDSHAKE_RST);
        send_frame(4, lfbd_pkg::FOOTER_RST);
        repeat (4) send_word(lfbd_pkg::HANDSHAKE_RST);
    endtask

    task automatic test_long_frame();
        apply_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     {$urandom, $urandom}, 4'($urandom_range(0, 15)));
        send_frame(40, ftr_code);
    endtask

    // receiver: random stall, with a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= dst_idle_en && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: word mismatch, expected none, actual event %0d data %0d",
                         $time, o_event_res, o_data);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("event", 8'(want.ev), 8'(o_event_res));
                check_field("data", want.data, o_data);
                check_field("position", want.pos, o_position);
                check_field("frame_length", want.flen, o_frame_length);
                check_field("last", 8'(want.last), 8'(o_last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, %0d words still expected", $time,
                     expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_code_overlap();
        test_random_traffic();
        test_output_holdoff();
        test_long_frame();
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d words never arrived", $time, expected_results.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
